// File: rtl/core/slzc_pkg.sv
// Shared types, constants and helper functions for the sound level zone classifier.
package slzc_pkg;

    localparam int LEVEL_W = 12;
    localparam int AVG_W   = 20;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int IDX_W   = 4;
    localparam int DATA_W  = 24;
    localparam int GAIN_W  = 9;
    localparam int CMP_W   = 22;

    localparam logic [COLOR_W-1:0] QUIET_COLOR = 24'h00FF00;
    localparam logic [COLOR_W-1:0] WARN_COLOR  = 24'hFFFF00;
    localparam logic [COLOR_W-1:0] LOUD_COLOR  = 24'hFF0000;

    localparam logic [GAIN_W-1:0] GAIN_MAX = 9'd256;

    localparam logic [IDX_W-1:0] REG_MODE         = 4'd0;
    localparam logic [IDX_W-1:0] REG_MANUAL_COLOR = 4'd1;
    localparam logic [IDX_W-1:0] REG_ZONE_MASK    = 4'd2;
    localparam logic [IDX_W-1:0] REG_INACTIVE     = 4'd3;
    localparam logic [IDX_W-1:0] REG_LOW_THRESH   = 4'd4;
    localparam logic [IDX_W-1:0] REG_HIGH_THRESH  = 4'd5;
    localparam logic [IDX_W-1:0] REG_HYSTERESIS   = 4'd6;
    localparam logic [IDX_W-1:0] REG_GAIN         = 4'd7;

    localparam logic [1:0] MODE_CODE_INVALID = 2'd3;
    localparam logic [2:0] MASK_ALL          = 3'd7;

    typedef enum logic [1:0] {
        MODE_AUTO   = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_OFF    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ZONE_UNKNOWN = 2'd0,
        ZONE_QUIET   = 2'd1,
        ZONE_WARN    = 2'd2,
        ZONE_LOUD    = 2'd3
    } zone_t;

    typedef struct packed {
        mode_t              mode;
        logic [COLOR_W-1:0] manual_color;
        logic [2:0]         zone_mask;
        logic [7:0]         inactive_level;
        logic [7:0]         low_threshold_db;
        logic [7:0]         high_threshold_db;
        logic [7:0]         hysteresis;
        logic [GAIN_W-1:0]  smoothing_gain;
    } cfg_t;

    typedef struct packed {
        zone_t              zone;
        logic               zone_changed;
        logic [COLOR_W-1:0] rgb;
    } result_t;

    // Exact floor(x / 255) for any 16-bit x below 65280, which covers every 8-bit by 8-bit product.
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    function automatic logic [COLOR_W-1:0] scale_color(input logic [COLOR_W-1:0] rgb,
                                                       input logic [7:0] lvl);
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        r = rgb[23:16] * lvl;
        g = rgb[15:8] * lvl;
        b = rgb[7:0] * lvl;
        return {div255(r), div255(g), div255(b)};
    endfunction

    function automatic zone_t classify(input logic [AVG_W-1:0] avg, input zone_t from,
                                       input cfg_t c);
        logic signed [CMP_W-1:0] v;
        logic signed [CMP_W-1:0] lo;
        logic signed [CMP_W-1:0] hi;
        logic signed [CMP_W-1:0] h;
        zone_t nz;
        v  = signed'({2'b00, avg});
        lo = signed'({2'b00, c.low_threshold_db, 12'd0});
        hi = signed'({2'b00, c.high_threshold_db, 12'd0});
        h  = signed'({6'd0, c.hysteresis, 8'd0});
        unique case (from)
            ZONE_QUIET:
            begin
                if (v > hi + h)      nz = ZONE_LOUD;
                else if (v > lo + h) nz = ZONE_WARN;
                else                 nz = ZONE_QUIET;
            end
            ZONE_WARN:
            begin
                if (v > hi + h)      nz = ZONE_LOUD;
                else if (v < lo - h) nz = ZONE_QUIET;
                else                 nz = ZONE_WARN;
            end
            ZONE_LOUD:
            begin
                if (v < lo - h)      nz = ZONE_QUIET;
                else if (v < hi - h) nz = ZONE_WARN;
                else                 nz = ZONE_LOUD;
            end
            ZONE_UNKNOWN:
            begin
                if (v > hi)      nz = ZONE_LOUD;
                else if (v > lo) nz = ZONE_WARN;
                else             nz = ZONE_QUIET;
            end
        endcase
        return nz;
    endfunction

    function automatic logic [COLOR_W-1:0] target_color(input zone_t z, input cfg_t c);
        logic [COLOR_W-1:0] lamp;
        logic               covered;
        logic [COLOR_W-1:0] col;
        if (c.zone_mask[2])      lamp = LOUD_COLOR;
        else if (c.zone_mask[1]) lamp = WARN_COLOR;
        else                     lamp = QUIET_COLOR;
        unique case (z)
            ZONE_QUIET:   covered = c.zone_mask[0];
            ZONE_WARN:    covered = c.zone_mask[1];
            ZONE_LOUD:    covered = c.zone_mask[2];
            ZONE_UNKNOWN: covered = 1'b1;
        endcase
        unique case (z)
            ZONE_QUIET:   col = QUIET_COLOR;
            ZONE_WARN:    col = WARN_COLOR;
            ZONE_LOUD:    col = LOUD_COLOR;
            ZONE_UNKNOWN: col = '0;
        endcase
        priority case (c.mode)
            MODE_OFF:    col = '0;
            MODE_MANUAL: col = c.manual_color;
            default:
            begin
                if (!covered)
                    col = (c.inactive_level == 8'd0) ? '0 : scale_color(lamp, c.inactive_level);
            end
        endcase
        return col;
    endfunction

endpackage

// File: rtl/core/slzc_cfg.sv
// Configuration register file with write decode and the clear pulse on entering auto mode.
module slzc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [slzc_pkg::IDX_W-1:0]  wr_index,
    input  logic [slzc_pkg::DATA_W-1:0] wr_data,
    output slzc_pkg::cfg_t              cfg,
    output logic                        clear
);
    import slzc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic clear_next;

    always_comb
    begin
        cfg_next   = cfg_reg;
        clear_next = 1'b0;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_MODE:
                begin
                    if (wr_data[1:0] != MODE_CODE_INVALID && wr_data[1:0] != cfg_reg.mode)
                    begin
                        cfg_next.mode = mode_t'(wr_data[1:0]);
                        clear_next    = (mode_t'(wr_data[1:0]) == MODE_AUTO);
                    end
                end
                REG_MANUAL_COLOR: cfg_next.manual_color = wr_data[COLOR_W-1:0];
                REG_ZONE_MASK:
                    cfg_next.zone_mask = (wr_data[2:0] == 3'd0) ? MASK_ALL : wr_data[2:0];
                REG_INACTIVE:     cfg_next.inactive_level    = wr_data[7:0];
                REG_LOW_THRESH:   cfg_next.low_threshold_db  = wr_data[7:0];
                REG_HIGH_THRESH:  cfg_next.high_threshold_db = wr_data[7:0];
                REG_HYSTERESIS:   cfg_next.hysteresis        = wr_data[7:0];
                REG_GAIN:         cfg_next.smoothing_gain    = wr_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode              <= MODE_AUTO;
            cfg_reg.manual_color      <= QUIET_COLOR;
            cfg_reg.zone_mask         <= MASK_ALL;
            cfg_reg.inactive_level    <= 8'd0;
            cfg_reg.low_threshold_db  <= 8'd55;
            cfg_reg.high_threshold_db <= 8'd70;
            cfg_reg.hysteresis        <= 8'd32;
            cfg_reg.smoothing_gain    <= 9'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg   = cfg_reg;
    assign clear = clear_next;

endmodule

// File: rtl/core/slzc_core.sv
// Average, zone state and the per-sample update that produces one result.
module slzc_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  slzc_pkg::cfg_t               cfg,
    input  logic                         clear,
    input  logic                         step,
    input  logic [slzc_pkg::LEVEL_W-1:0] level,
    output slzc_pkg::result_t            result
);
    import slzc_pkg::*;

    logic [AVG_W-1:0]  average_reg;
    logic [AVG_W-1:0]  average_next;
    logic              average_valid_reg;
    logic              average_valid_next;
    zone_t             zone_reg;
    zone_t             zone_next;

    logic [AVG_W-1:0]  x;
    logic [GAIN_W-1:0] gain;
    logic              rising;
    logic [AVG_W-1:0]  diff;
    logic [28:0]       prod;
    logic [AVG_W-1:0]  delta;
    logic [AVG_W-1:0]  avg_upd;
    zone_t             zone_upd;
    logic              auto_mode;

    assign auto_mode = (cfg.mode == MODE_AUTO);
    assign x         = {level, 8'd0};
    assign gain      = (cfg.smoothing_gain > GAIN_MAX) ? GAIN_MAX : cfg.smoothing_gain;
    assign rising    = (x >= average_reg);
    assign diff      = rising ? (x - average_reg) : (average_reg - x);
    // The rounded step never exceeds the distance, so it fits the average width.
    assign prod      = gain * diff + 29'd128;
    assign delta     = prod[27:8];

    always_comb
    begin
        if (!average_valid_reg)
            avg_upd = x;
        else if (rising)
            avg_upd = average_reg + delta;
        else
            avg_upd = average_reg - delta;
    end

    assign zone_upd = classify(avg_upd, zone_reg, cfg);

    always_comb
    begin
        average_next       = average_reg;
        average_valid_next = average_valid_reg;
        zone_next          = zone_reg;
        if (clear)
        begin
            average_next       = '0;
            average_valid_next = 1'b0;
            zone_next          = ZONE_UNKNOWN;
        end
        else if (step && auto_mode)
        begin
            average_next       = avg_upd;
            average_valid_next = 1'b1;
            zone_next          = zone_upd;
        end
    end

    always_comb
    begin
        result.zone         = auto_mode ? zone_upd : zone_reg;
        result.zone_changed = auto_mode && (zone_upd != zone_reg);
        result.rgb          = target_color(result.zone, cfg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            average_reg       <= '0;
            average_valid_reg <= 1'b0;
            zone_reg          <= ZONE_UNKNOWN;
        end
        else
        begin
            average_reg       <= average_next;
            average_valid_reg <= average_valid_next;
            zone_reg          <= zone_next;
        end
    end

endmodule

// File: rtl/core/sound_level_zone_classifier_top.sv
// Top level of the sound level zone classifier: input register, core and result register.
//
// Each level beat updates, in auto mode, an exponential average of the sound level,
// classifies it into the quiet, warn or loud zone with hysteresis, and returns one
// result beat with the zone, a zone-changed flag and the lamp colour. The block takes
// one level beat every cycle while the result register is empty or being emptied; an
// accepted beat waits in the input register, its result is held in an output register,
// and the input register can take one more beat while a result waits; the combinational
// average update loop sets the rate. Configuration writes are accepted every cycle and
// take effect from the next cycle; write them only while no level beat is in flight.
module sound_level_zone_classifier_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [slzc_pkg::LEVEL_W-1:0] level,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   zone,
    output logic                         zone_changed,
    output logic [slzc_pkg::CHAN_W-1:0]  red,
    output logic [slzc_pkg::CHAN_W-1:0]  green,
    output logic [slzc_pkg::CHAN_W-1:0]  blue,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [slzc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [slzc_pkg::DATA_W-1:0]  cfg_data
);
    import slzc_pkg::*;

    cfg_t             cfg;
    logic             clear;
    result_t          result;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [LEVEL_W-1:0] level_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_reg;
    logic               advance;

    assign cfg_ready = 1'b1;

    slzc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg),
        .clear    (clear)
    );

    // The held level moves on when the result register is empty or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    slzc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .clear  (clear),
        .step   (advance),
        .level  (level_reg),
        .result (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = in_valid;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            level_reg <= level;
        if (advance)
            out_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign zone         = out_reg.zone;
    assign zone_changed = out_reg.zone_changed;
    assign red          = out_reg.rgb[23:16];
    assign green        = out_reg.rgb[15:8];
    assign blue         = out_reg.rgb[7:0];

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the sound level zone classifier top level.
`timescale 1ns / 1ps

module testbench;
    import slzc_pkg::*;

    localparam int RESULT_LATENCY = 2;
    localparam int END_WAIT_LIMIT = 4000;
    localparam int RANDOM_LEVELS  = 1250;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [LEVEL_W-1:0]  level;
    logic                out_valid;
    logic                out_ready;
    logic [1:0]          zone;
    logic                zone_changed;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [DATA_W-1:0]   cfg_data;

    // Predictor copy of the registers and of the averaging state.
    mode_t               p_mode;
    logic [COLOR_W-1:0]  p_manual;
    logic [2:0]          p_mask;
    logic [7:0]          p_inactive;
    logic [7:0]          p_low;
    logic [7:0]          p_high;
    logic [7:0]          p_hyst;
    logic [GAIN_W-1:0]   p_gain;
    logic [AVG_W-1:0]    p_average;
    logic                p_average_loaded;
    zone_t               p_zone;

    result_t             pending_results[$];
    int                  mismatch_count;
    int                  levels_sent;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    sound_level_zone_classifier_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .level        (level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .zone         (zone),
        .zone_changed (zone_changed),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [COLOR_W-1:0] zone_color(input zone_t z);
        case (z)
            ZONE_QUIET: return QUIET_COLOR;
            ZONE_WARN:  return WARN_COLOR;
            ZONE_LOUD:  return LOUD_COLOR;
            default:    return '0;
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] dim_lamp(input logic [COLOR_W-1:0] rgb,
                                                    input logic [7:0] lvl);
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        r = (16'(rgb[23:16]) * 16'(lvl)) / 16'd255;
        g = (16'(rgb[15:8]) * 16'(lvl)) / 16'd255;
        b = (16'(rgb[7:0]) * 16'(lvl)) / 16'd255;
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    // All compares are done on signed ints so that a threshold minus margin may go negative.
    function automatic zone_t next_zone_of(input logic [AVG_W-1:0] avg, input zone_t from);
        int v;
        int lo;
        int hi;
        int hm;
        v  = int'(avg);
        lo = int'(p_low) * 4096;
        hi = int'(p_high) * 4096;
        hm = int'(p_hyst) * 256;
        case (from)
            ZONE_QUIET:
            begin
                if (v > hi + hm)      return ZONE_LOUD;
                else if (v > lo + hm) return ZONE_WARN;
                else                  return ZONE_QUIET;
            end
            ZONE_WARN:
            begin
                if (v > hi + hm)      return ZONE_LOUD;
                else if (v < lo - hm) return ZONE_QUIET;
                else                  return ZONE_WARN;
            end
            ZONE_LOUD:
            begin
                if (v < lo - hm)      return ZONE_QUIET;
                else if (v < hi - hm) return ZONE_WARN;
                else                  return ZONE_LOUD;
            end
            default:
            begin
                if (v > hi)      return ZONE_LOUD;
                else if (v > lo) return ZONE_WARN;
                else             return ZONE_QUIET;
            end
        endcase
    endfunction

    function automatic result_t predict_beat(input logic [LEVEL_W-1:0] lv);
        result_t            res;
        logic [AVG_W-1:0]   x;
        logic [GAIN_W-1:0]  g;
        logic [31:0]        step;
        zone_t              nz;
        logic               covered;
        logic [COLOR_W-1:0] lamp;
        res.zone_changed = 1'b0;
        if (p_mode == MODE_AUTO)
        begin
            x = {lv, 8'd0};
            if (!p_average_loaded)
            begin
                p_average        = x;
                p_average_loaded = 1'b1;
            end
            else
            begin
                g = (p_gain > GAIN_MAX) ? GAIN_MAX : p_gain;
                if (x >= p_average)
                begin
                    step      = (32'(g) * 32'(x - p_average) + 32'd128) >> 8;
                    p_average = p_average + step[AVG_W-1:0];
                end
                else
                begin
                    step      = (32'(g) * 32'(p_average - x) + 32'd128) >> 8;
                    p_average = p_average - step[AVG_W-1:0];
                end
            end
            nz = next_zone_of(p_average, p_zone);
            if (nz != p_zone)
            begin
                p_zone           = nz;
                res.zone_changed = 1'b1;
            end
        end
        res.zone = p_zone;
        if (p_mode == MODE_OFF)
            res.rgb = '0;
        else if (p_mode == MODE_MANUAL)
            res.rgb = p_manual;
        else
        begin
            case (p_zone)
                ZONE_QUIET: covered = p_mask[0];
                ZONE_WARN:  covered = p_mask[1];
                ZONE_LOUD:  covered = p_mask[2];
                default:    covered = 1'b1;
            endcase
            if (p_mask[2])      lamp = LOUD_COLOR;
            else if (p_mask[1]) lamp = WARN_COLOR;
            else                lamp = QUIET_COLOR;
            if (!covered)
                res.rgb = (p_inactive == 8'd0) ? '0 : dim_lamp(lamp, p_inactive);
            else
                res.rgb = zone_color(p_zone);
        end
        return res;
    endfunction

    task automatic apply_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        case (idx)
            REG_MODE:
            begin
                if (data[1:0] != MODE_CODE_INVALID && data[1:0] != p_mode)
                begin
                    p_mode = mode_t'(data[1:0]);
                    if (p_mode == MODE_AUTO)
                    begin
                        p_zone           = ZONE_UNKNOWN;
                        p_average        = '0;
                        p_average_loaded = 1'b0;
                    end
                end
            end
            REG_MANUAL_COLOR: p_manual   = data[COLOR_W-1:0];
            REG_ZONE_MASK:    p_mask     = (data[2:0] == 3'd0) ? MASK_ALL : data[2:0];
            REG_INACTIVE:     p_inactive = data[7:0];
            REG_LOW_THRESH:   p_low      = data[7:0];
            REG_HIGH_THRESH:  p_high     = data[7:0];
            REG_HYSTERESIS:   p_hyst     = data[7:0];
            REG_GAIN:         p_gain     = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s at %0t: got %0d, want %0d", field, $realtime, got, want);
        mismatch_count++;
    endtask

    // Every result beat is matched against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", int'(zone), -1);
            else
            begin
                want = pending_results.pop_front();
                if (zone != want.zone)
                    report_mismatch("zone", int'(zone), int'(want.zone));
                if (zone_changed != want.zone_changed)
                    report_mismatch("zone_changed", int'(zone_changed),
                                    int'(want.zone_changed));
                if (red != want.rgb[23:16])
                    report_mismatch("red", int'(red), int'(want.rgb[23:16]));
                if (green != want.rgb[15:8])
                    report_mismatch("green", int'(green), int'(want.rgb[15:8]));
                if (blue != want.rgb[7:0])
                    report_mismatch("blue", int'(blue), int'(want.rgb[7:0]));
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic send_level(input logic [LEVEL_W-1:0] lv);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        level    <= lv;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(predict_beat(lv));
        levels_sent++;
    endtask

    // The sender holds off until every predicted beat has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 1) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_value(input int lo, input int hi);
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Sets the unused upper data bits at random now and then; the block must ignore them.
    function automatic logic [DATA_W-1:0] with_noise(input int value, input int width);
        logic [31:0] junk;
        junk = $urandom();
        if ($urandom_range(0, 2) != 0)
            junk = '0;
        return DATA_W'(((junk >> width) << width) | 32'(value));
    endfunction

    task automatic test_first_sample();
        send_level(12'd0);
        send_level(12'd4095);
        send_level(12'd4095);
    endtask

    task automatic test_gain_extremes();
        write_reg(REG_GAIN, 24'd256);
        send_level(12'd0);
        send_level(12'd4095);
        write_reg(REG_GAIN, 24'h0001FF);
        send_level(12'd1200);
        write_reg(REG_GAIN, 24'd0);
        send_level(12'd0);
    endtask

    task automatic test_threshold_extremes();
        write_reg(REG_GAIN, 24'd256);
        write_reg(REG_LOW_THRESH, 24'd0);
        write_reg(REG_HIGH_THRESH, 24'd255);
        write_reg(REG_HYSTERESIS, 24'd0);
        send_level(12'd0);
        send_level(12'd4095);
        // Low above high: the compares still follow the hysteresis rules literally.
        write_reg(REG_HYSTERESIS, 24'd255);
        write_reg(REG_LOW_THRESH, 24'd255);
        write_reg(REG_HIGH_THRESH, 24'd0);
        send_level(12'd0);
        send_level(12'd4095);
        send_level(12'd2000);
    endtask

    task automatic test_zone_mask();
        write_reg(REG_LOW_THRESH, 24'd55);
        write_reg(REG_HIGH_THRESH, 24'd70);
        write_reg(REG_HYSTERESIS, 24'd32);
        write_reg(REG_ZONE_MASK, 24'd1);
        write_reg(REG_INACTIVE, 24'd0);
        send_level(12'd4095);
        write_reg(REG_INACTIVE, 24'd255);
        send_level(12'd4095);
        write_reg(REG_ZONE_MASK, 24'd2);
        write_reg(REG_INACTIVE, 24'd128);
        send_level(12'd0);
        send_level(12'd1000);
        write_reg(REG_ZONE_MASK, 24'hFFFFF8);
        send_level(12'd4095);
    endtask

    task automatic test_modes_and_writes();
        write_reg(REG_MODE, 24'hFFFFFC | 24'(MODE_CODE_INVALID));
        send_level(12'd4095);
        write_reg(REG_MODE, 24'(MODE_MANUAL));
        write_reg(REG_MANUAL_COLOR, 24'hFFFFFF);
        send_level(12'd0);
        write_reg(REG_MANUAL_COLOR, 24'h000000);
        send_level(12'd0);
        write_reg(REG_MODE, 24'(MODE_OFF));
        send_level(12'd4095);
        write_reg(4'd15, 24'hFFFFFF);
        write_reg(REG_MODE, 24'(MODE_MANUAL));
        // Back to auto: average and zone start over from the next beat.
        write_reg(REG_MODE, 24'(MODE_AUTO));
        send_level(12'd1000);
    endtask

    task automatic randomize_config();
        int pick;
        if ($urandom_range(0, 9) < 7) write_reg(REG_MANUAL_COLOR, 24'(pick_value(0, 24'hFFFFFF)));
        if ($urandom_range(0, 9) < 7) write_reg(REG_ZONE_MASK, with_noise(pick_value(0, 7), 3));
        if ($urandom_range(0, 9) < 7) write_reg(REG_INACTIVE, with_noise(pick_value(0, 255), 8));
        if ($urandom_range(0, 9) < 7) write_reg(REG_LOW_THRESH, with_noise(pick_value(0, 255), 8));
        if ($urandom_range(0, 9) < 7) write_reg(REG_HIGH_THRESH, with_noise(pick_value(0, 255), 8));
        if ($urandom_range(0, 9) < 7) write_reg(REG_HYSTERESIS, with_noise(pick_value(0, 255), 8));
        if ($urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(0, 7))
                0:       pick = 0;
                1:       pick = 511;
                2:       pick = $urandom_range(257, 511);
                default: pick = pick_value(1, 256);
            endcase
            write_reg(REG_GAIN, with_noise(pick, GAIN_W));
        end
        if ($urandom_range(0, 4) == 0)
            write_reg(IDX_W'($urandom_range(8, 15)), DATA_W'($urandom()));
        case ($urandom_range(0, 9))
            0: write_reg(REG_MODE, with_noise(int'(MODE_MANUAL), 2));
            1: write_reg(REG_MODE, with_noise(int'(MODE_OFF), 2));
            2: write_reg(REG_MODE, with_noise(int'(MODE_CODE_INVALID), 2));
            3:
            begin
                write_reg(REG_MODE, 24'(MODE_MANUAL));
                write_reg(REG_MODE, with_noise(int'(MODE_AUTO), 2));
            end
            default: write_reg(REG_MODE, with_noise(int'(MODE_AUTO), 2));
        endcase
    endtask

    // Levels come in runs: some wander at random, most hover around a threshold so the
    // average creeps across it and the hysteresis bands are exercised.
    task automatic random_levels(input int count);
        int left;
        int run;
        int base;
        int spread;
        int lv;
        left = count;
        while (left > 0)
        begin
            run = $urandom_range(1, 24);
            if (run > left)
                run = left;
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    base   = 2048;
                    spread = 2048;
                end
                3, 4, 5:
                begin
                    base   = int'(p_low) * 16;
                    spread = int'(p_hyst) + 8;
                end
                default:
                begin
                    base   = int'(p_high) * 16;
                    spread = int'(p_hyst) + 8;
                end
            endcase
            base = base + $urandom_range(0, 2 * spread) - spread;
            repeat (run)
            begin
                lv = (spread >= 2048) ? $urandom_range(0, 4095) : base + $urandom_range(0, 6) - 3;
                if (lv < 0)
                    lv = 0;
                if (lv > 4095)
                    lv = 4095;
                send_level(LEVEL_W'(lv));
            end
            left -= run;
            if ($urandom_range(0, 19) == 0)
                drain_results();
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = levels_sent + count;
        while (levels_sent < target)
        begin
            randomize_config();
            random_levels($urandom_range(20, 70));
        end
    endtask

    initial
    begin
        int waited;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        level            = '0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        mismatch_count   = 0;
        levels_sent      = 0;
        send_idle_pct    = 19;
        recv_idle_pct    = 60;
        p_mode           = MODE_AUTO;
        p_manual         = 24'h00FF00;
        p_mask           = MASK_ALL;
        p_inactive       = 8'd0;
        p_low            = 8'd55;
        p_high           = 8'd70;
        p_hyst           = 8'd32;
        p_gain           = 9'd64;
        p_average        = '0;
        p_average_loaded = 1'b0;
        p_zone           = ZONE_UNKNOWN;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_first_sample();
        test_gain_extremes();
        test_threshold_extremes();
        test_zone_mask();
        test_modes_and_writes();
        test_random_traffic(19, 60, RANDOM_LEVELS / 3);
        test_random_traffic(60, 19, RANDOM_LEVELS / 3);
        test_random_traffic(0, 0, RANDOM_LEVELS / 3);

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < END_WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (RESULT_LATENCY + 4) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("result beats never delivered", 0, pending_results.size());
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/slzc_pkg.sv
rtl/core/slzc_cfg.sv
rtl/core/slzc_core.sv
rtl/core/sound_level_zone_classifier_top.sv
sim/testbench.sv
